// File: hdl/bilateral_grid_vertex_hasher_assert.svh
// Assertion macros for the bilateral grid vertex hasher.
`ifndef BILATERAL_GRID_VERTEX_HASHER_ASSERT_SVH
`define BILATERAL_GRID_VERTEX_HASHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define BGVH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bilateral grid hasher: check failed");
// Check on every clock edge, reset included.
`define BGVH_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bilateral grid hasher: check failed");
`else
`define BGVH_ASSERT(lbl, prop)
`define BGVH_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hdl/bgvh_pkg.sv
// Shared types and constants of the bilateral grid vertex hasher.
`default_nettype none
package bgvh_pkg;

    localparam int COORD_W    = 12;
    localparam int KEY_W      = 53;
    localparam int VERT_W     = 12;
    localparam int PIX_W      = 16;
    localparam int VCOUNT_W   = 13;
    localparam int DIMS_W     = 3;
    localparam int NUM_COORDS = 6;
    localparam int MIN_DIMS   = 3;

    localparam int DEF_MAX_VERTICES = 4096;
    localparam int DEF_TABLE_SLOTS  = 8192;
    localparam int DEF_MAX_DIMS     = 6;
    localparam int DEF_HASH_BASE    = 255;

    localparam logic [DIMS_W-1:0] NUM_DIMS_RESET = 3'd5;

    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_HASH,
        ST_PROBE,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: hdl/bgvh_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bgvh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: hdl/bilateral_grid_vertex_hasher.sv
// Top level of the bilateral grid vertex hasher: key hash, probe loop, table RAM.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid, in_ready, action, coord_0..5    | key item or clear
//  out     | out_valid, out_ready, vertex_index, ...   | one result per item
//  cfg     | cfg_valid, cfg_ready, cfg_data            | num_dims register write
//
// A lookup runs num_dims - 1 Horner steps of the key, then P table probes (one RAM read
// each, P >= 1), then a result state that waits until the output register is free.
// A clear wipes the table at one entry per cycle.
// After reset the same wipe runs over all TABLE_SLOTS entries with in_ready low; cfg is open.
// One item is in work at a time; the output register holds a result while out_ready is low.
`default_nettype none
`include "bilateral_grid_vertex_hasher_assert.svh"
module bilateral_grid_vertex_hasher #(
    parameter int MAX_VERTICES = bgvh_pkg::DEF_MAX_VERTICES,
    parameter int TABLE_SLOTS  = bgvh_pkg::DEF_TABLE_SLOTS,
    parameter int MAX_DIMS     = bgvh_pkg::DEF_MAX_DIMS,
    parameter int HASH_BASE    = bgvh_pkg::DEF_HASH_BASE
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [bgvh_pkg::COORD_W-1:0]   coord_0,
    input  wire logic [bgvh_pkg::COORD_W-1:0]   coord_1,
    input  wire logic [bgvh_pkg::COORD_W-1:0]   coord_2,
    input  wire logic [bgvh_pkg::COORD_W-1:0]   coord_3,
    input  wire logic [bgvh_pkg::COORD_W-1:0]   coord_4,
    input  wire logic [bgvh_pkg::COORD_W-1:0]   coord_5,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [bgvh_pkg::VERT_W-1:0]    vertex_index,
    output logic                                is_new,
    output logic      [bgvh_pkg::PIX_W-1:0]     pixel_index,
    output logic      [bgvh_pkg::VCOUNT_W-1:0]  vertex_count,
    output logic                                overflow,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bgvh_pkg::DIMS_W-1:0]    cfg_data
);

    // TABLE_SLOTS must be a power of two (the block does not check it): the home slot is the low key bits.
    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int LIMIT   = (MAX_VERTICES < TABLE_SLOTS) ? MAX_VERTICES : TABLE_SLOTS;
    localparam int VCNT_W  = $clog2(LIMIT + 1);
    localparam int STEP_W  = $clog2(MAX_DIMS);
    localparam int KEY_W   = bgvh_pkg::KEY_W;
    localparam int VERT_W  = bgvh_pkg::VERT_W;
    localparam int ENTRY_W = 1 + KEY_W + VERT_W;
    localparam logic [KEY_W-1:0] BASE_K = KEY_W'(HASH_BASE);

    bgvh_pkg::state_t state_reg, state_next;

    logic [bgvh_pkg::COORD_W-1:0] port_coord [bgvh_pkg::NUM_COORDS];
    logic [bgvh_pkg::COORD_W-1:0] in_coord   [MAX_DIMS];
    logic [bgvh_pkg::COORD_W-1:0] coord_reg  [MAX_DIMS];
    logic [bgvh_pkg::COORD_W-1:0] coord_next [MAX_DIMS];

    logic [bgvh_pkg::DIMS_W-1:0] num_dims_reg, num_dims_next, dims_eff;
    logic [STEP_W-1:0]           top_idx;
    logic [KEY_W-1:0]            key_reg, key_next, key_step;
    logic [STEP_W-1:0]           step_reg, step_next;
    logic [SLOT_W-1:0]           slot_reg, slot_next;
    logic [SLOT_W-1:0]           probe_reg, probe_next;
    logic [SLOT_W-1:0]           clr_cnt_reg, clr_cnt_next;
    logic                        clr_emit_reg, clr_emit_next;
    logic [VCNT_W-1:0]           vcount_reg, vcount_next;
    logic [bgvh_pkg::PIX_W-1:0]  pix_reg, pix_next;

    logic [VERT_W-1:0]             res_vert_reg, res_vert_next;
    logic                          res_new_reg, res_new_next;
    logic [bgvh_pkg::PIX_W-1:0]    res_pix_reg, res_pix_next;
    logic [bgvh_pkg::VCOUNT_W-1:0] res_vcount_reg, res_vcount_next;
    logic                          res_ovf_reg, res_ovf_next;

    logic                          out_valid_reg, out_valid_next;
    logic [VERT_W-1:0]             out_vert_reg, out_vert_next;
    logic                          out_new_reg, out_new_next;
    logic [bgvh_pkg::PIX_W-1:0]    out_pix_reg, out_pix_next;
    logic [bgvh_pkg::VCOUNT_W-1:0] out_vcount_reg, out_vcount_next;
    logic                          out_ovf_reg, out_ovf_next;

    logic                ram_we, ram_re;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

    logic                e_valid, hit, free_slot, last_probe, not_full, out_free;
    logic [KEY_W-1:0]    e_key;
    logic [VERT_W-1:0]   e_vert;
    logic [31:0]         vert_wide, vcount_wide;

    assign port_coord[0] = coord_0;
    assign port_coord[1] = coord_1;
    assign port_coord[2] = coord_2;
    assign port_coord[3] = coord_3;
    assign port_coord[4] = coord_4;
    assign port_coord[5] = coord_5;

    always_comb
    begin
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            in_coord[i] = port_coord[i];
        end
    end

    // Clamp the dimension count into the supported range.
    always_comb
    begin
        if (num_dims_reg < bgvh_pkg::DIMS_W'(bgvh_pkg::MIN_DIMS))
        begin
            dims_eff = bgvh_pkg::DIMS_W'(bgvh_pkg::MIN_DIMS);
        end
        else if (num_dims_reg > bgvh_pkg::DIMS_W'(MAX_DIMS))
        begin
            dims_eff = bgvh_pkg::DIMS_W'(MAX_DIMS);
        end
        else
        begin
            dims_eff = num_dims_reg;
        end
    end

    assign top_idx  = STEP_W'(dims_eff - bgvh_pkg::DIMS_W'(1));
    assign key_step = KEY_W'(key_reg * BASE_K) + KEY_W'(coord_reg[step_reg]);

    assign e_valid    = ram_rdata[ENTRY_W-1];
    assign e_key      = ram_rdata[VERT_W +: KEY_W];
    assign e_vert     = ram_rdata[VERT_W-1:0];
    assign hit        = e_valid && (e_key == key_reg);
    assign free_slot  = !e_valid;
    assign last_probe = (probe_reg == SLOT_W'(TABLE_SLOTS - 1));
    assign not_full   = (vcount_reg < VCNT_W'(LIMIT));
    assign out_free   = !out_valid_reg || out_ready;
    assign vert_wide  = 32'(vcount_reg);

    assign in_ready  = (state_reg == bgvh_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bgvh_pkg::ST_SWEEP:
            begin
                if (clr_cnt_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    state_next = clr_emit_reg ? bgvh_pkg::ST_DONE : bgvh_pkg::ST_IDLE;
                end
            end
            bgvh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (action == bgvh_pkg::ACT_CLEAR) ? bgvh_pkg::ST_SWEEP
                                                                 : bgvh_pkg::ST_HASH;
                end
            end
            bgvh_pkg::ST_HASH:
            begin
                if (step_reg == '0)
                begin
                    state_next = bgvh_pkg::ST_PROBE;
                end
            end
            bgvh_pkg::ST_PROBE:
            begin
                if (hit || free_slot || last_probe)
                begin
                    state_next = bgvh_pkg::ST_DONE;
                end
            end
            bgvh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = bgvh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bgvh_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM controls and result registers.
    always_comb
    begin
        num_dims_next   = num_dims_reg;
        coord_next      = coord_reg;
        key_next        = key_reg;
        step_next       = step_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_emit_next   = clr_emit_reg;
        vcount_next     = vcount_reg;
        pix_next        = pix_reg;
        res_vert_next   = res_vert_reg;
        res_new_next    = res_new_reg;
        res_pix_next    = res_pix_reg;
        res_vcount_next = res_vcount_reg;
        res_ovf_next    = res_ovf_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_vert_next   = out_vert_reg;
        out_new_next    = out_new_reg;
        out_pix_next    = out_pix_reg;
        out_vcount_next = out_vcount_reg;
        out_ovf_next    = out_ovf_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot_reg;
        ram_wdata       = {1'b1, key_reg, vert_wide[VERT_W-1:0]};
        vcount_wide     = 32'(vcount_reg);

        if (cfg_valid)
        begin
            num_dims_next = cfg_data;
        end

        unique case (state_reg)
            bgvh_pkg::ST_SWEEP:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + SLOT_W'(1);
                if (clr_cnt_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    clr_emit_next   = 1'b0;
                    res_vert_next   = '0;
                    res_new_next    = 1'b0;
                    res_pix_next    = '0;
                    res_vcount_next = '0;
                    res_ovf_next    = 1'b0;
                end
            end
            bgvh_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == bgvh_pkg::ACT_CLEAR)
                    begin
                        clr_cnt_next  = '0;
                        clr_emit_next = 1'b1;
                        vcount_next   = '0;
                        pix_next      = '0;
                    end
                    else
                    begin
                        coord_next = in_coord;
                        key_next   = KEY_W'(in_coord[top_idx]);
                        step_next  = top_idx - STEP_W'(1);
                    end
                end
            end
            bgvh_pkg::ST_HASH:
            begin
                key_next  = key_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    slot_next  = key_step[SLOT_W-1:0];
                    probe_next = '0;
                end
            end
            bgvh_pkg::ST_PROBE:
            begin
                if (hit || free_slot || last_probe)
                begin
                    res_new_next  = 1'b0;
                    res_ovf_next  = 1'b0;
                    res_vert_next = '0;
                    if (hit)
                    begin
                        res_vert_next = e_vert;
                    end
                    else if (free_slot && not_full)
                    begin
                        ram_we        = 1'b1;
                        res_vert_next = vert_wide[VERT_W-1:0];
                        res_new_next  = 1'b1;
                        vcount_next   = vcount_reg + VCNT_W'(1);
                    end
                    else
                    begin
                        res_ovf_next = 1'b1;
                    end
                    vcount_wide     = 32'(vcount_next);
                    res_vcount_next = vcount_wide[bgvh_pkg::VCOUNT_W-1:0];
                    res_pix_next    = pix_reg;
                    if (pix_reg != '1)
                    begin
                        pix_next = pix_reg + bgvh_pkg::PIX_W'(1);
                    end
                end
                else
                begin
                    // Advance to the next slot; the index wraps at the table end.
                    slot_next  = slot_reg + SLOT_W'(1);
                    probe_next = probe_reg + SLOT_W'(1);
                end
            end
            bgvh_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vert_next   = res_vert_reg;
                    out_new_next    = res_new_reg;
                    out_pix_next    = res_pix_reg;
                    out_vcount_next = res_vcount_reg;
                    out_ovf_next    = res_ovf_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Read the slot that the probe state looks at in the next cycle.
    assign ram_re = (state_next == bgvh_pkg::ST_PROBE);

    bgvh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bgvh_pkg::ST_SWEEP;
            num_dims_reg  <= bgvh_pkg::NUM_DIMS_RESET;
            clr_cnt_reg   <= '0;
            clr_emit_reg  <= 1'b0;
            vcount_reg    <= '0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            num_dims_reg  <= num_dims_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_emit_reg  <= clr_emit_next;
            vcount_reg    <= vcount_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg      <= coord_next;
        key_reg        <= key_next;
        step_reg       <= step_next;
        slot_reg       <= slot_next;
        probe_reg      <= probe_next;
        res_vert_reg   <= res_vert_next;
        res_new_reg    <= res_new_next;
        res_pix_reg    <= res_pix_next;
        res_vcount_reg <= res_vcount_next;
        res_ovf_reg    <= res_ovf_next;
        out_vert_reg   <= out_vert_next;
        out_new_reg    <= out_new_next;
        out_pix_reg    <= out_pix_next;
        out_vcount_reg <= out_vcount_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_vert_reg;
    assign is_new       = out_new_reg;
    assign pixel_index  = out_pix_reg;
    assign vertex_count = out_vcount_reg;
    assign overflow     = out_ovf_reg;

    `BGVH_ASSERT(a_new_xor_ovf, out_valid |-> !(is_new && overflow))
    `BGVH_ASSERT_ALWAYS(a_vcount_bound, vcount_reg <= VCNT_W'(LIMIT))
    `BGVH_ASSERT(a_clear_sweep, (in_valid && in_ready && action == bgvh_pkg::ACT_CLEAR) |=> (state_reg == bgvh_pkg::ST_SWEEP && vcount_reg == '0 && clr_emit_reg))
    `BGVH_ASSERT(a_no_read_in_sweep, (state_reg == bgvh_pkg::ST_SWEEP) |-> !ram_re)

endmodule
`default_nettype wire
